FILE: sv/park_pkg.sv
package park_pkg;

  // Sample and table geometry
  localparam int SAMPLE_WIDTH     = 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int ANGLE_WIDTH      = 16;
  localparam int OUT_WIDTH        = SAMPLE_WIDTH + 1;
  localparam int TAB_W            = SAMPLE_WIDTH - 1;
  localparam int K_W              = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_W            = K_W + 1;
  localparam int POS_W            = K_W + 2;
  localparam int PHASE_W          = 32;
  localparam int PROD_W           = 48;

  // Stream packing
  localparam int IN_TDATA_W  = ((5 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((4 * OUT_WIDTH + 7) / 8) * 8;

  // Turns per radian in Q0.32, and pi/2 in Q2.30
  localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;
  localparam longint unsigned    HALF_PI_Q30  = 64'd1686629713;
  localparam longint unsigned    ONE_Q30      = 64'd1 << 30;

  typedef logic signed [SAMPLE_WIDTH-1:0]  sample_t;
  typedef logic signed [OUT_WIDTH-1:0]     result_t;
  typedef logic [TAB_W-1:0]                tab_val_t;
  typedef logic [SINE_TABLE_DEPTH:0][TAB_W-1:0] sine_tab_t;

  // Series divisors of the nested sine polynomial
  localparam longint unsigned TAYLOR_DIVS [6] = '{64'd156, 64'd110, 64'd72,
                                                   64'd42, 64'd20, 64'd6};

  // One quarter-wave entry: sine of k/DEPTH * pi/2, scaled to full scale
  function automatic longint unsigned tab_entry(longint unsigned k);
    longint unsigned amp;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    amp = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
    x   = (k * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
    x2  = (x * x) >> 30;
    t   = ONE_Q30;
    for (int i = 0; i < 6; i++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIVS[i];
    end
    s = (x * t) >> 30;
    v = (s * amp + (64'd1 << 29)) >> 30;
    if (v > amp) begin
      v = amp;
    end
    return v;
  endfunction

  // Build the whole quarter-wave table at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      tab[i] = TAB_W'(tab_entry(64'(i)));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: sv/park_transform_forward_inverse.sv
// Forward and inverse Park transform, one item in, one item out.
// Input stream in_*: tdata carries alpha, beta, d, q (Q1.15) and the
// electrical angle (Q4.12 radians, any value, wrapped modulo two pi).
// Output stream out_*: tdata carries d, q (forward of alpha/beta) and
// alpha, beta (inverse of d/q), each Q2.15, both from the same angle.
// Sine and cosine come from a quarter-wave constant table.
// Throughput: one item per cycle while out_tready is high; the
// six-stage pipeline (input register, phase multiply, table index,
// table read, eight 16x16 products, sum and round) moves one step per
// clock when the receiver does not stall it.
// Each stage advances when its successor is empty or advancing, so a
// stalled receiver only holds the output register; earlier stages keep
// filling and in_tready drops once all six stages hold items.
// Reset (rst_n low, synchronous) empties the pipeline; items in flight
// are dropped and out_tvalid goes low.
module park_transform_forward_inverse (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // alpha_in, beta_in, d_in, q_in, angle
  input  logic [park_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // d_out, q_out, alpha_out, beta_out, zero padding
  output logic [park_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int SW = park_pkg::SAMPLE_WIDTH;

  // Stage valid bits and advance enables
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en0, en1, en2, en3, en4, en5;

  // Stage 0: input register
  park_pkg::sample_t al0_r, be0_r, dd0_r, qq0_r;
  logic signed [park_pkg::ANGLE_WIDTH-1:0] ang0_r;

  // Stage 1: phase
  park_pkg::sample_t al1_r, be1_r, dd1_r, qq1_r;
  logic [park_pkg::PHASE_W-1:0] phase1_r, phase_nxt;
  logic signed [park_pkg::PROD_W-1:0] ang_prod;

  // Stage 2: table indexes and signs
  park_pkg::sample_t al2_r, be2_r, dd2_r, qq2_r;
  logic [park_pkg::IDX_W-1:0] sidx2_r, cidx2_r, sidx_nxt, cidx_nxt;
  logic sneg2_r, cneg2_r, sneg_nxt, cneg_nxt;
  logic [park_pkg::PHASE_W:0] pos_sum;
  logic [park_pkg::POS_W-1:0] spos, cpos;

  // Stage 3: signed sine and cosine
  park_pkg::sample_t al3_r, be3_r, dd3_r, qq3_r;
  park_pkg::sample_t sn3_r, cs3_r, sn_nxt, cs_nxt;

  // Stage 4: products
  logic signed [2*SW-1:0] p_alc_r, p_als_r, p_bes_r, p_bec_r;
  logic signed [2*SW-1:0] p_ddc_r, p_dds_r, p_qqs_r, p_qqc_r;

  // Stage 5: results
  park_pkg::result_t d5_r, q5_r, alpha5_r, beta5_r;
  park_pkg::result_t d_nxt, q_nxt, alpha_nxt, beta_nxt;

  // Fold a full-turn table position into a quarter-wave table index
  function automatic logic [park_pkg::IDX_W-1:0] tab_index(
    input logic [park_pkg::POS_W-1:0] pos
  );
    logic [park_pkg::IDX_W-1:0] k;
    k = park_pkg::IDX_W'(pos[park_pkg::K_W-1:0]);
    if (pos[park_pkg::K_W]) begin
      return park_pkg::IDX_W'(park_pkg::SINE_TABLE_DEPTH) - k;
    end
    return k;
  endfunction

  // Read the table and apply the half-turn sign
  function automatic park_pkg::sample_t tab_read(
    input logic [park_pkg::IDX_W-1:0] idx,
    input logic                       neg
  );
    park_pkg::sample_t mag;
    mag = SW'(park_pkg::SINE_TAB[idx]);
    return neg ? -mag : mag;
  endfunction

  // Round a two-product sum half up to Q2.15
  function automatic park_pkg::result_t dot_round(
    input logic signed [2*SW-1:0] a,
    input logic signed [2*SW-1:0] b,
    input logic                   sub
  );
    logic signed [2*SW:0] sum;
    sum = (2*SW+1)'(a) + (sub ? -(2*SW+1)'(b) : (2*SW+1)'(b));
    sum = sum + ((2*SW+1)'(1) << (SW - 2));
    return sum[2*SW-1:SW-1];
  endfunction

  // Advance chain: a stage moves when its successor is empty or moving
  assign en5 = !v5_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_tready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 0: capture the item
  always_ff @(posedge clk) begin
    if (en0) begin
      al0_r  <= in_tdata[0*SW +: SW];
      be0_r  <= in_tdata[1*SW +: SW];
      dd0_r  <= in_tdata[2*SW +: SW];
      qq0_r  <= in_tdata[3*SW +: SW];
      ang0_r <= in_tdata[4*SW +: park_pkg::ANGLE_WIDTH];
    end
  end

  // Stage 1: angle to rounded Q0.32 fraction of a turn
  always_comb begin
    ang_prod  = park_pkg::PROD_W'(ang0_r) * park_pkg::PROD_W'(park_pkg::TURN_PER_RAD)
                + park_pkg::PROD_W'(2048);
    phase_nxt = ang_prod[12 +: park_pkg::PHASE_W];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      al1_r    <= al0_r;
      be1_r    <= be0_r;
      dd1_r    <= dd0_r;
      qq1_r    <= qq0_r;
      phase1_r <= phase_nxt;
    end
  end

  // Stage 2: round phase to a table position, wrap at a full turn
  always_comb begin
    pos_sum  = {1'b0, phase1_r}
               + ((park_pkg::PHASE_W+1)'(1) << (park_pkg::PHASE_W - park_pkg::POS_W - 1));
    spos     = pos_sum[park_pkg::PHASE_W - park_pkg::POS_W +: park_pkg::POS_W];
    cpos     = spos + park_pkg::POS_W'(park_pkg::SINE_TABLE_DEPTH);
    sidx_nxt = tab_index(spos);
    cidx_nxt = tab_index(cpos);
    sneg_nxt = spos[park_pkg::POS_W-1];
    cneg_nxt = cpos[park_pkg::POS_W-1];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      al2_r   <= al1_r;
      be2_r   <= be1_r;
      dd2_r   <= dd1_r;
      qq2_r   <= qq1_r;
      sidx2_r <= sidx_nxt;
      cidx2_r <= cidx_nxt;
      sneg2_r <= sneg_nxt;
      cneg2_r <= cneg_nxt;
    end
  end

  // Stage 3: table read
  always_comb begin
    sn_nxt = tab_read(sidx2_r, sneg2_r);
    cs_nxt = tab_read(cidx2_r, cneg2_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      al3_r <= al2_r;
      be3_r <= be2_r;
      dd3_r <= dd2_r;
      qq3_r <= qq2_r;
      sn3_r <= sn_nxt;
      cs3_r <= cs_nxt;
    end
  end

  // Stage 4: eight products
  always_ff @(posedge clk) begin
    if (en4) begin
      p_alc_r <= al3_r * cs3_r;
      p_als_r <= al3_r * sn3_r;
      p_bes_r <= be3_r * sn3_r;
      p_bec_r <= be3_r * cs3_r;
      p_ddc_r <= dd3_r * cs3_r;
      p_dds_r <= dd3_r * sn3_r;
      p_qqs_r <= qq3_r * sn3_r;
      p_qqc_r <= qq3_r * cs3_r;
    end
  end

  // Stage 5: sum pairs and round
  always_comb begin
    d_nxt     = dot_round(p_alc_r, p_bes_r, 1'b0);
    q_nxt     = dot_round(p_bec_r, p_als_r, 1'b1);
    alpha_nxt = dot_round(p_ddc_r, p_qqs_r, 1'b1);
    beta_nxt  = dot_round(p_dds_r, p_qqc_r, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      d5_r     <= d_nxt;
      q5_r     <= q_nxt;
      alpha5_r <= alpha_nxt;
      beta5_r  <= beta_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = park_pkg::OUT_TDATA_W'({beta5_r, alpha5_r, q5_r, d5_r});

endmodule

FILE: sv/park_chk.sv
module park_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [park_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int USED_W = 4 * park_pkg::OUT_WIDTH;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // An empty output register means nothing blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Padding above the four results stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[park_pkg::OUT_TDATA_W-1:USED_W] == '0)
    else $error("output padding not zero");

endmodule

bind park_transform_forward_inverse park_chk u_park_chk (.*);

FILE: verif/tb_park_transform_forward_inverse.sv
`timescale 1ns / 1ps

module tb_park_transform_forward_inverse;

  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_TAIL   = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  // One result item, highest field first so the packed form matches out_tdata
  typedef struct packed {
    park_pkg::result_t beta;
    park_pkg::result_t alpha;
    park_pkg::result_t q;
    park_pkg::result_t d;
  } rotation_t;

  // Expected rotations, worked out from each accepted item
  class park_scoreboard;
    localparam longint signed   RAD_TO_TURN = 64'sd683565276;
    localparam longint unsigned QUARTER_PI2 = 64'd1686629713;
    localparam longint unsigned UNIT_Q30    = 64'd1 << 30;
    localparam longint unsigned FULL_SCALE  = 64'd32767;
    localparam int              DEPTH       = 1024;

    longint signed quarter_sine [0:DEPTH];
    rotation_t     rotation_q [$];
    int            errors;

    function new();
      for (int k = 0; k <= DEPTH; k++) begin
        quarter_sine[k] = longint'(sine_entry(64'(k)));
      end
      errors = 0;
    endfunction

    // Nested series for sin(k/DEPTH * pi/2), scaled to full scale and rounded
    function longint unsigned sine_entry(longint unsigned k);
      longint unsigned divisor [6];
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned v;
      divisor = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      x  = (k * QUARTER_PI2 + 64'(DEPTH / 2)) / 64'(DEPTH);
      x2 = (x * x) >> 30;
      t  = UNIT_Q30;
      for (int i = 0; i < 6; i++) begin
        t = UNIT_Q30 - ((x2 * t) >> 30) / divisor[i];
      end
      s = (x * t) >> 30;
      v = (s * FULL_SCALE + (64'd1 << 29)) >> 30;
      if (v > FULL_SCALE) begin
        v = FULL_SCALE;
      end
      return v;
    endfunction

    // Fold a table position into the quarter wave by quadrant
    function longint signed sine_at(int unsigned pos);
      int unsigned k;
      k = pos % DEPTH;
      case (pos / DEPTH)
        0: return quarter_sine[k];
        1: return quarter_sine[DEPTH - k];
        2: return -quarter_sine[k];
        default: return -quarter_sine[DEPTH - k];
      endcase
    endfunction

    // Exact sum of two products, rounded half up to Q2.15
    function park_pkg::result_t rotate_round(longint signed a, longint signed b,
                                             longint signed c, longint signed s);
      logic [63:0] acc;
      logic [63:0] r;
      acc = a * c + b * s;
      r   = (acc + 64'd16384) >> 15;
      return r[park_pkg::OUT_WIDTH-1:0];
    endfunction

    // Map the angle to a turn fraction, then to a table position
    function rotation_t park_predict(park_pkg::sample_t al, park_pkg::sample_t be,
                                     park_pkg::sample_t dd, park_pkg::sample_t qq,
                                     park_pkg::sample_t ang);
      logic [63:0]   prod;
      logic [63:0]   phase;
      logic [63:0]   pos;
      int unsigned   spos;
      int unsigned   cpos;
      longint signed sn;
      longint signed cs;
      rotation_t     r;
      prod  = longint'(ang) * RAD_TO_TURN;
      phase = ((prod + 64'd2048) >> 12) & 64'hFFFF_FFFF;
      pos   = (phase * 64'(4 * DEPTH) + (64'd1 << 31)) >> 32;
      spos  = int'(pos);
      if (spos >= 4 * DEPTH) begin
        spos = spos - 4 * DEPTH;
      end
      cpos = spos + DEPTH;
      if (cpos >= 4 * DEPTH) begin
        cpos = cpos - 4 * DEPTH;
      end
      sn = sine_at(spos);
      cs = sine_at(cpos);
      r.d     = rotate_round(longint'(al), longint'(be), cs, sn);
      r.q     = rotate_round(longint'(al), longint'(be), -sn, cs);
      r.alpha = rotate_round(longint'(dd), longint'(qq), cs, -sn);
      r.beta  = rotate_round(longint'(dd), longint'(qq), sn, cs);
      return r;
    endfunction

    function void note_item(park_pkg::sample_t al, park_pkg::sample_t be,
                            park_pkg::sample_t dd, park_pkg::sample_t qq,
                            park_pkg::sample_t ang);
      rotation_q.push_back(park_predict(al, be, dd, qq, ang));
    endfunction

    function void compare_field(string field, park_pkg::result_t expv,
                                park_pkg::result_t actv);
      if (expv !== actv) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d",
                 $time, field, expv, actv);
        errors++;
      end
    endfunction

    function void check_result(logic [park_pkg::OUT_TDATA_W-1:0] tdata);
      rotation_t expv;
      rotation_t actv;
      actv = tdata[4*park_pkg::OUT_WIDTH-1:0];
      if (rotation_q.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual %h",
                 $time, actv);
        errors++;
      end else begin
        expv = rotation_q.pop_front();
        compare_field("d_out", expv.d, actv.d);
        compare_field("q_out", expv.q, actv.q);
        compare_field("alpha_out", expv.alpha, actv.alpha);
        compare_field("beta_out", expv.beta, actv.beta);
      end
    endfunction

    function int pending();
      return rotation_q.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  // alpha_in, beta_in, d_in, q_in, angle
  logic [park_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // d_out, q_out, alpha_out, beta_out, zero padding
  logic [park_pkg::OUT_TDATA_W-1:0] out_tdata;

  park_scoreboard rotation_board = new();

  bit tail_quiet   = 1'b0;
  bit send_idling  = 1'b0;
  bit recv_idling  = 1'b0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  park_transform_forward_inverse uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item after an optional gap, hold it until accepted
  task automatic send_item(input park_pkg::sample_t al, input park_pkg::sample_t be,
                           input park_pkg::sample_t dd, input park_pkg::sample_t qq,
                           input park_pkg::sample_t ang);
    int gap;
    gap = 0;
    if (!tail_quiet && send_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ang, qq, dd, be, al};
    do @(posedge clk); while (!in_tready);
    rotation_board.note_item(al, be, dd, qq, ang);
  endtask

  // Mostly uniform samples, with the extremes and values near zero now and then
  function automatic park_pkg::sample_t rand_sample();
    case ($urandom_range(0, 11))
      0: return park_pkg::sample_t'(-32768);
      1: return park_pkg::sample_t'(32767);
      2: return park_pkg::sample_t'($urandom_range(0, 2)) - park_pkg::sample_t'(1);
      default: return park_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Check results and stall the receiver in bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rotation_board.check_result(out_tdata);
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!tail_quiet && recv_idling && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // End the run when neither side moves an item for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_park_transform_forward_inverse: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sample extremes, quadrant angles, wrap around a full turn
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd32767, 16'sd0, 16'sd32767, 16'sd0, 16'sd0);
    send_item(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd0);
    send_item(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd6434);
    send_item(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd12868);
    send_item(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd19302);
    send_item(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd25735);
    send_item(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd25736);
    send_item(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd1);
    send_item(16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1);
    send_item(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767);
    send_item(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768);
    send_item(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd6434);
    send_item(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, -16'sd12868);
    send_item(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd25736);
    send_item(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd3217);
    send_item(16'sd12345, 16'sd23456, -16'sd12345, -16'sd23456, 16'sd9651);
    send_item(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'sd16085);

    // Random: vary idling per stretch, no idling at the tail
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        send_idling = ($urandom_range(0, 3) != 0);
        recv_idling = ($urandom_range(0, 3) != 0);
      end
      if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
        tail_quiet = 1'b1;
      end
      send_item(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                rand_sample());
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every expected result, then a few extra cycles
    while (rotation_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (rotation_board.errors == 0 && rotation_board.pending() == 0) begin
      $display("tb_park_transform_forward_inverse: PASS");
    end else begin
      $display("tb_park_transform_forward_inverse: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/park_pkg.sv
sv/park_transform_forward_inverse.sv
sv/park_chk.sv
verif/tb_park_transform_forward_inverse.sv
